// File: design/tifc_pkg.sv
// Package for the tape image format checker.
// Holds the word types, command and phase codes and framing constants.
// No dependencies.
package tifc_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 24;
    localparam int COUNT_BITS  = 16;

    // even-padded length can reach 2^LENGTH_BITS
    localparam int LEFT_BITS = LENGTH_BITS + 1;

    localparam logic [31:0] WORD_TM  = 32'h0000_0000;
    localparam logic [31:0] WORD_GAP = 32'hFFFF_FFFE;
    localparam logic [31:0] WORD_EOM = 32'hFFFF_FFFF;
    localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);
    localparam logic [31:0] MBZ_MASK = 32'h7FFF_FFFF & ~LEN_MASK;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_END     = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_DATA    = 2'd1,
        PH_TRAILER = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        VD_VALID   = 2'd0,
        VD_ERRORS  = 2'd1,
        VD_CORRUPT = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] mark_offset;
        logic [15:0] error_records;
    } t_out_word;

endpackage

// File: design/tape_image_format_checker.sv
// Tape image format checker: takes one byte of a tape image per word, with
// commands to end the image or restart, and gives one verdict word (valid,
// valid with error records, corrupt) with the offset of the final mark and
// the error record count. One input word is taken every cycle unless the
// result register holds a verdict not yet taken; each word goes through
// an input register, the combinational parse logic and a result register.
// Input stalls only while the result register holds a verdict not yet taken.
// Depends on tifc_pkg, tifc_core and tifc_out_reg.
module tape_image_format_checker
    import tifc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      free;
    logic      load_in;
    logic      go;
    logic      emit;
    t_out_word result;

    assign load_in    = !r_in_valid || free;
    assign o_in_stall = !load_in;
    assign go         = r_in_valid && free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load_in) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_in_word <= i_in_word;
        end
    end

    tifc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_word   (r_in_word),
        .o_emit   (emit),
        .o_result (result)
    );

    tifc_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (go && emit),
        .i_word      (result),
        .i_out_stall (i_out_stall),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// File: design/tifc_core.sv
// Framing state and verdict logic of the tape image format checker.
// Updates the parse state for one registered input word per cycle while i_go is set.
// Depends on tifc_pkg.
module tifc_core
    import tifc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_go,
    input  t_in_word  i_word,
    output logic      o_emit,
    output t_out_word o_result
);

    t_phase                 r_phase,  n_phase;
    logic [1:0]             r_biw,    n_biw;
    logic [31:0]            r_shift,  n_shift;
    logic [31:0]            r_saved,  n_saved;
    logic [LEFT_BITS-1:0]   r_left,   n_left;
    logic                   r_mark,   n_mark;
    logic [COUNT_BITS-1:0]  r_tally,  n_tally;
    logic [OFFSET_BITS-1:0] r_pos,    n_pos;
    logic [OFFSET_BITS-1:0] r_wstart, n_wstart;
    logic                   r_finished, n_finished;

    t_cmd                   cmd;
    logic [31:0]            full_word;
    logic                   word_done;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [LEFT_BITS-1:0]   left_init;
    logic                   mbz_bad;
    logic                   tally_max;

    logic                   s_emit;
    t_verdict               s_verdict;
    logic [OFFSET_BITS-1:0] s_offset;
    logic [OFFSET_BITS+31:0] offset_ext;
    logic [COUNT_BITS+15:0] tally_ext;

    assign cmd       = t_cmd'(i_word.command);
    assign full_word = {i_word.data_byte, r_shift[31:8]};
    assign word_done = (r_biw == 2'd3);
    assign pos_inc   = r_pos + OFFSET_BITS'(1);
    assign left_init = {1'b0, full_word[LENGTH_BITS-1:0]} + LEFT_BITS'(full_word[0]);
    assign mbz_bad   = ((full_word & MBZ_MASK) != 32'd0);
    assign tally_max = &r_tally;

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_biw      = r_biw;
        n_shift    = r_shift;
        n_saved    = r_saved;
        n_left     = r_left;
        n_mark     = r_mark;
        n_tally    = r_tally;
        n_pos      = r_pos;
        n_wstart   = r_wstart;
        n_finished = r_finished;
        if (i_go) begin
            unique case (cmd)
                CMD_RESTART: begin
                    n_phase    = PH_HEADER;
                    n_biw      = '0;
                    n_shift    = '0;
                    n_saved    = '0;
                    n_left     = '0;
                    n_mark     = 1'b0;
                    n_tally    = '0;
                    n_pos      = '0;
                    n_wstart   = '0;
                    n_finished = 1'b0;
                end
                CMD_END: begin
                    n_finished = 1'b1;
                end
                CMD_BYTE: begin
                    if (!r_finished) begin
                        if (r_phase == PH_DATA) begin
                            // skip data and padding
                            n_pos  = pos_inc;
                            n_left = r_left - LEFT_BITS'(1);
                            if (r_left == LEFT_BITS'(1)) begin
                                n_phase = PH_TRAILER;
                            end
                        end else begin
                            if (r_biw == 2'd0) begin
                                n_wstart = r_pos;
                            end
                            n_pos   = pos_inc;
                            n_shift = full_word;
                            n_biw   = r_biw + 2'd1;
                            if (word_done) begin
                                if (r_phase == PH_TRAILER) begin
                                    n_phase = PH_HEADER;
                                    if (full_word != r_saved) begin
                                        n_finished = 1'b1;
                                    end
                                end else if (full_word == WORD_TM) begin
                                    if (!r_mark) begin
                                        n_mark = 1'b1;
                                    end else begin
                                        n_finished = 1'b1;
                                    end
                                end else if (full_word == WORD_EOM) begin
                                    n_finished = 1'b1;
                                end else if (full_word != WORD_GAP) begin
                                    n_mark  = 1'b0;
                                    n_saved = full_word;
                                    if (full_word[31] && !tally_max) begin
                                        n_tally = r_tally + COUNT_BITS'(1);
                                    end
                                    if (mbz_bad) begin
                                        n_finished = 1'b1;
                                    end else begin
                                        n_left  = left_init;
                                        n_phase = (left_init != '0) ? PH_DATA : PH_TRAILER;
                                    end
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result
    always_comb begin
        s_emit    = 1'b0;
        s_verdict = VD_CORRUPT;
        s_offset  = '0;
        if (i_go && !r_finished) begin
            if (cmd == CMD_END) begin
                s_emit = 1'b1;
                if (r_phase == PH_HEADER && r_biw == 2'd0) begin
                    // end at a word boundary is an implied mark
                    s_verdict = (n_tally != '0) ? VD_ERRORS : VD_VALID;
                    s_offset  = r_pos;
                end
            end else if (cmd == CMD_BYTE && r_phase != PH_DATA && word_done) begin
                if (r_phase == PH_TRAILER) begin
                    s_emit = (full_word != r_saved);
                end else if ((full_word == WORD_TM && r_mark) || full_word == WORD_EOM) begin
                    s_emit    = 1'b1;
                    s_verdict = (n_tally != '0) ? VD_ERRORS : VD_VALID;
                    s_offset  = r_wstart;
                end else if (full_word != WORD_TM && full_word != WORD_GAP) begin
                    s_emit = mbz_bad;
                end
            end
        end
    end

    assign offset_ext = {32'd0, s_offset};
    assign tally_ext  = {16'd0, n_tally};

    assign o_emit                 = s_emit;
    assign o_result.verdict       = s_verdict;
    assign o_result.mark_offset   = offset_ext[31:0];
    assign o_result.error_records = tally_ext[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_biw      <= '0;
            r_shift    <= '0;
            r_saved    <= '0;
            r_left     <= '0;
            r_mark     <= 1'b0;
            r_tally    <= '0;
            r_pos      <= '0;
            r_wstart   <= '0;
            r_finished <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_biw      <= n_biw;
            r_shift    <= n_shift;
            r_saved    <= n_saved;
            r_left     <= n_left;
            r_mark     <= n_mark;
            r_tally    <= n_tally;
            r_pos      <= n_pos;
            r_wstart   <= n_wstart;
            r_finished <= n_finished;
        end
    end

endmodule

// File: design/tifc_out_reg.sv
// Result register of the tape image format checker.
// Holds one verdict word until the downstream side takes it.
// Depends on tifc_pkg.
module tifc_out_reg
    import tifc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_out_word i_word,
    input  logic      i_out_stall,
    output logic      o_free,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    logic      r_valid;
    t_out_word r_word;

    // free when empty or the held word leaves this cycle
    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_word <= i_word;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule
